[sv/velocity_kalman_tracker_core_assert.svh]
// Assertion macros for the velocity Kalman tracker core.
// Included by the modules that carry concurrent assertions; no other dependencies.
`ifndef VELOCITY_KALMAN_TRACKER_CORE_ASSERT_SVH
`define VELOCITY_KALMAN_TRACKER_CORE_ASSERT_SVH
`ifndef SYNTHESIS
// Consequent must hold in the same cycle as the antecedent.
`define VKT_ASSERT_NOW(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("velocity tracker assertion failed");
// Consequent must hold in the cycle after the antecedent.
`define VKT_ASSERT_NEXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("velocity tracker assertion failed");
`else
`define VKT_ASSERT_NOW(lbl, ck, rs, ante, cons)
`define VKT_ASSERT_NEXT(lbl, ck, rs, ante, cons)
`endif
`endif

[sv/vkt_pkg.sv]
// Shared types, constants and helper functions for the velocity Kalman tracker.
// Used by every module of the block; depends on nothing else.
package vkt_pkg;

  // Fixed-point format of covariance and gain.
  localparam int COV_FRAC_BITS = 30;
  localparam int KW            = COV_FRAC_BITS + 1;

  // Shared multiplier operand width and product width.
  localparam int MUL_W = 33;
  localparam int PRD_W = 2 * MUL_W;

  // Iterative divider widths.
  localparam int DIV_Q_W   = 32;
  localparam int DIV_D_W   = 48;
  localparam int DIV_CNT_W = $clog2(DIV_Q_W + 1);

  // Width used for saturating sums.
  localparam int SAT_W = PRD_W;

  localparam logic signed [31:0] INT32_MAX = 32'sh7fff_ffff;
  localparam logic signed [31:0] INT32_MIN = 32'sh8000_0000;

  localparam logic [KW-1:0] COV_ONE_K = KW'(1) << COV_FRAC_BITS;
  localparam logic [63:0]   COV_ONE_W = 64'd1 << COV_FRAC_BITS;

  // Register reset values: 0.001 and 0.1 in the covariance format.
  localparam logic [31:0] PN_RESET  = 32'((COV_ONE_W + 64'd500) / 64'd1000);
  localparam logic [31:0] MN_RESET  = 32'((COV_ONE_W + 64'd5) / 64'd10);
  localparam logic [31:0] COV_RESET = 32'(COV_ONE_W);

  localparam logic signed [MUL_W-1:0] US_PER_S = MUL_W'(1000000);

  // Configuration register indexes.
  localparam logic [0:0] CFG_PROCESS_NOISE     = 1'b0;
  localparam logic [0:0] CFG_MEASUREMENT_NOISE = 1'b1;

  typedef struct packed {
    logic               target_present;
    logic signed [31:0] target_distance;
    logic [47:0]        sample_time;
    logic signed [31:0] own_speed;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] relative_velocity;
    logic signed [31:0] filtered_velocity;
    logic               time_error;
  } out_item_t;

  // Request to the iterative divider.
  typedef struct packed {
    logic               start;
    logic [DIV_D_W-1:0] rem_init;
    logic [DIV_Q_W-1:0] dividend;
    logic [DIV_D_W-1:0] divisor;
  } div_req_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL_RAW,
    S_DIV_RAW_START,
    S_DIV_RAW,
    S_REL,
    S_GAIN_START,
    S_DIV_GAIN,
    S_MUL_CORR,
    S_UPD_X,
    S_UPD_P,
    S_FINISH
  } state_t;

  // Saturate a wide signed value to 32 bits.
  function automatic logic signed [31:0] sat_to_32(input logic signed [SAT_W-1:0] v);
    logic signed [31:0] r;
    if (v > SAT_W'(INT32_MAX)) begin
      r = INT32_MAX;
    end else if (v < SAT_W'(INT32_MIN)) begin
      r = INT32_MIN;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

[sv/vkt_mult.sv]
// Shared signed multiplier with a registered product.
// Depends on vkt_pkg for operand and product widths.
module vkt_mult import vkt_pkg::*; (
  input  logic                    clk,
  input  logic signed [MUL_W-1:0] a,
  input  logic signed [MUL_W-1:0] b,
  output logic signed [PRD_W-1:0] product
);

  // Product is available in the cycle after the operands are presented.
  always_ff @(posedge clk) begin
    product <= a * b;
  end

endmodule

[sv/vkt_divider.sv]
// Restoring divider that produces one quotient bit per cycle.
// Depends on vkt_pkg for the request struct and widths.
module vkt_divider import vkt_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  div_req_t           req,
  output logic               done,
  output logic [DIV_Q_W-1:0] quotient
);

  logic [DIV_D_W-1:0]   rem;
  logic [DIV_Q_W-1:0]   work;
  logic [DIV_D_W-1:0]   divisor;
  logic [DIV_CNT_W-1:0] count;
  logic                 busy;

  logic [DIV_D_W:0] rem_sh;
  logic [DIV_D_W:0] rem_diff;
  logic             fits;

  // One step: shift in the next dividend bit and subtract where it fits.
  always_comb begin
    rem_sh   = {rem, work[DIV_Q_W-1]};
    rem_diff = rem_sh - {1'b0, divisor};
    fits     = rem_sh >= {1'b0, divisor};
  end

  // Step counter and completion flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy  <= 1'b1;
        count <= DIV_CNT_W'(DIV_Q_W);
      end else if (busy) begin
        count <= count - DIV_CNT_W'(1);
        if (count == DIV_CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Partial remainder and the dividend register, which fills with quotient bits.
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem     <= req.rem_init;
      work    <= req.dividend;
      divisor <= req.divisor;
    end else if (busy) begin
      rem  <= fits ? rem_diff[DIV_D_W-1:0] : rem_sh[DIV_D_W-1:0];
      work <= {work[DIV_Q_W-2:0], fits};
    end
  end

  assign quotient = work;

endmodule

[sv/velocity_kalman_tracker_core.sv]
// Top level of the velocity Kalman tracker: sequencer, state and output register.
// Depends on vkt_pkg, vkt_mult, vkt_divider and the assertion macro header.
//
// Usage. Input transactions arrive on in_valid/in_ready with an in_item_t payload.
// An item without a target is taken without leaving idle and gives no result. An item with
// a target is differentiated against the previous target item, corrected by the
// absolute own speed and passed through a scalar Kalman update; one result then
// leaves on out_valid/out_ready as an out_item_t.
// Sequence. The work on a target item is set mostly by two 32-step passes of the
// shared restoring divider (velocity quotient and Kalman gain), plus three passes
// through the shared multiplier. The next transaction can be taken from the cycle
// after the result is loaded, so a target item is finished before the next is taken.
// A zero time step or a saturating quotient skips the matching divider pass, and a
// zero time step skips the whole filter update, so such items finish sooner.
// in_ready is high whenever the sequencer is idle, also while a result waits.
// Stalls. If the receiver holds out_ready low, the finished result waits in the
// output register; a following result is held back until the register is free.
// Reset. rst zeroes the estimate and history, sets the covariance to one, fills the
// noise registers with defaults, empties the output register. Configuration writes
// on cfg_write are taken at once and must only be issued while the block is idle.
`include "velocity_kalman_tracker_core_assert.svh"

module velocity_kalman_tracker_core import vkt_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_data,
  input  logic        cfg_write,
  input  logic [0:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  state_t state, state_next;

  // Architectural state and configuration.
  logic signed [31:0] prev_dist;
  logic [47:0]        prev_time;
  logic signed [31:0] x_est;
  logic [31:0]        cov;
  logic [31:0]        pn_reg;
  logic [31:0]        mn_reg;

  // Per-item working registers.
  logic signed [32:0] diff;
  logic [47:0]        dt;
  logic [31:0]        abs_speed;
  logic               terr;
  logic signed [31:0] raw;
  logic signed [31:0] rel;
  logic [31:0]        pm;
  logic [KW-1:0]      k_gain;

  // Shared units.
  logic signed [MUL_W-1:0] mul_a, mul_b;
  logic signed [PRD_W-1:0] product;
  div_req_t                div_req;
  logic                    div_done;
  logic [DIV_Q_W-1:0]      quotient;

  // Combinational helpers.
  logic                    accept, out_free;
  logic signed [32:0]      diff_in;
  logic [47:0]             dt_in;
  logic [31:0]             abs_in;
  logic [PRD_W-1:0]        mag;
  logic                    raw_ovf;
  logic signed [31:0]      raw_sat, raw_q;
  logic signed [SAT_W-1:0] rel_sum, x_sum;
  logic [32:0]             pm_sum, den;
  logic signed [32:0]      innov;
  logic signed [PRD_W-COV_FRAC_BITS-1:0] corr;
  logic [31:0]             pn_new;
  logic                    gain_div;

  vkt_mult u_mult (
    .clk     (clk),
    .a       (mul_a),
    .b       (mul_b),
    .product (product)
  );

  vkt_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .req      (div_req),
    .done     (div_done),
    .quotient (quotient)
  );

  // Datapath arithmetic around the shared units.
  always_comb begin
    accept   = in_valid && in_ready;
    out_free = !out_valid || out_ready;
    diff_in  = $signed({in_data.target_distance[31], in_data.target_distance})
             - $signed({prev_dist[31], prev_dist});
    dt_in    = in_data.sample_time - prev_time;
    if (!in_data.own_speed[31]) begin
      abs_in = in_data.own_speed;
    end else if (in_data.own_speed == INT32_MIN) begin
      abs_in = INT32_MAX;
    end else begin
      abs_in = -in_data.own_speed;
    end

    // Magnitude of the scaled distance change; the quotient overflows 32 bits
    // exactly when the upper part already reaches the divisor.
    mag     = product[PRD_W-1] ? -product : product;
    raw_ovf = DIV_D_W'(mag[PRD_W-1:DIV_Q_W]) >= dt;
    if (terr) begin
      raw_sat = (diff == '0) ? 32'sd0 : (diff[32] ? INT32_MIN : INT32_MAX);
    end else begin
      raw_sat = product[PRD_W-1] ? INT32_MIN : INT32_MAX;
    end
    // The multiplier output has moved on by the time the quotient is ready, so the
    // sign comes from the stored distance change.
    if (diff[32]) begin
      raw_q = quotient[31] ? INT32_MIN : -$signed(quotient);
    end else begin
      raw_q = quotient[31] ? INT32_MAX : $signed(quotient);
    end

    rel_sum = SAT_W'(raw) + $signed({{(SAT_W-32){1'b0}}, abs_speed});
    pm_sum  = {1'b0, cov} + {1'b0, pn_reg};
    den     = {1'b0, pm} + {1'b0, mn_reg};
    innov   = $signed({rel[31], rel}) - $signed({x_est[31], x_est});
    corr    = $signed(product[PRD_W-1:COV_FRAC_BITS]);
    x_sum   = SAT_W'(x_est) + SAT_W'(corr);
    if (product[PRD_W-1:COV_FRAC_BITS+32] != '0) begin
      pn_new = '1;
    end else begin
      pn_new = product[COV_FRAC_BITS+31:COV_FRAC_BITS];
    end
    gain_div = (den != '0) && (mn_reg != '0);
  end

  // Operand selection for the shared multiplier.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_MUL_RAW: begin
        mul_a = diff;
        mul_b = US_PER_S;
      end
      S_MUL_CORR: begin
        mul_a = innov;
        mul_b = $signed({{(MUL_W-KW){1'b0}}, k_gain});
      end
      S_UPD_X: begin
        mul_a = $signed({{(MUL_W-KW){1'b0}}, COV_ONE_K - k_gain});
        mul_b = $signed({1'b0, pm});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Divider requests: velocity quotient, then the gain with the predicted covariance as
  // the initial remainder and two spare quotient bits.
  always_comb begin
    if (state == S_DIV_RAW_START) begin
      div_req.start    = !terr && !raw_ovf;
      div_req.rem_init = DIV_D_W'(mag[PRD_W-1:DIV_Q_W]);
      div_req.dividend = mag[DIV_Q_W-1:0];
      div_req.divisor  = dt;
    end else begin
      div_req.start    = (state == S_GAIN_START) && gain_div;
      div_req.rem_init = DIV_D_W'(pm);
      div_req.dividend = '0;
      div_req.divisor  = DIV_D_W'(den);
    end
  end

  // Next state and handshake outputs.
  always_comb begin
    state_next = state;
    in_ready   = (state == S_IDLE);
    unique case (state)
      S_IDLE: begin
        if (accept && in_data.target_present) state_next = S_MUL_RAW;
      end
      S_MUL_RAW:       state_next = S_DIV_RAW_START;
      S_DIV_RAW_START: state_next = (terr || raw_ovf) ? S_REL : S_DIV_RAW;
      S_DIV_RAW: begin
        if (div_done) state_next = S_REL;
      end
      S_REL:           state_next = terr ? S_FINISH : S_GAIN_START;
      S_GAIN_START:    state_next = gain_div ? S_DIV_GAIN : S_MUL_CORR;
      S_DIV_GAIN: begin
        if (div_done) state_next = S_MUL_CORR;
      end
      S_MUL_CORR:      state_next = S_UPD_X;
      S_UPD_X:         state_next = S_UPD_P;
      S_UPD_P:         state_next = S_FINISH;
      S_FINISH: begin
        if (out_free) state_next = S_IDLE;
      end
      default:         state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Filter state, configuration and the output valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_dist <= '0;
      prev_time <= '0;
      x_est     <= '0;
      cov       <= COV_RESET;
      pn_reg    <= PN_RESET;
      mn_reg    <= MN_RESET;
      out_valid <= 1'b0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          CFG_PROCESS_NOISE:     pn_reg <= cfg_data;
          CFG_MEASUREMENT_NOISE: mn_reg <= cfg_data;
          default: ;
        endcase
      end
      if (accept && in_data.target_present) begin
        prev_dist <= in_data.target_distance;
        prev_time <= in_data.sample_time;
      end
      if (state == S_UPD_X) x_est <= sat_to_32(x_sum);
      if (state == S_UPD_P) cov <= pn_new;
      if (state == S_FINISH && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Per-item working registers and the output payload.
  always_ff @(posedge clk) begin
    if (accept && in_data.target_present) begin
      diff      <= diff_in;
      dt        <= dt_in;
      abs_speed <= abs_in;
      terr      <= (dt_in == '0);
    end
    if (state == S_DIV_RAW_START) raw <= raw_sat;
    if (state == S_DIV_RAW && div_done) raw <= raw_q;
    if (state == S_REL) begin
      rel <= sat_to_32(rel_sum);
      pm  <= pm_sum[32] ? '1 : pm_sum[31:0];
    end
    if (state == S_GAIN_START) k_gain <= (mn_reg == '0 && den != '0) ? COV_ONE_K : '0;
    if (state == S_DIV_GAIN && div_done) begin
      k_gain <= KW'(quotient >> (DIV_Q_W - COV_FRAC_BITS));
    end
    if (state == S_FINISH && out_free) begin
      out_data.relative_velocity <= rel;
      out_data.filtered_velocity <= x_est;
      out_data.time_error        <= terr;
    end
  end

  // A target item holds off the next transaction while it is in progress.
  `VKT_ASSERT_NEXT(a_busy_after_target, clk, rst, accept && in_data.target_present, !in_ready)
  // The divider is only started with a partial remainder below the divisor.
  `VKT_ASSERT_NOW(a_div_start_ok, clk, rst, div_req.start, div_req.rem_init < div_req.divisor)
  // A new result only appears after the final sequencer step.
  `VKT_ASSERT_NOW(a_result_from_finish, clk, rst, $rose(out_valid), $past(state) == S_FINISH)
  // A zero time step bypasses the filter update entirely.
  `VKT_ASSERT_NEXT(a_terr_skips_filter, clk, rst, state == S_REL && terr, state == S_FINISH)

endmodule

[dv/velocity_track_checker.sv]
`timescale 1ns / 100ps
// Scoreboard for the velocity Kalman tracker core: watches the input, output and
// configuration ports, predicts every result and compares it. Depends on vkt_pkg.
module velocity_track_checker import vkt_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  in_item_t    in_data,
  input  logic        out_valid,
  input  logic        out_ready,
  input  out_item_t   out_data,
  input  logic        cfg_write,
  input  logic [0:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output int          mismatches,
  output int          outstanding
);

  localparam logic [63:0]        GAIN_ONE = 64'd1 << COV_FRAC_BITS;
  localparam logic [63:0]        CAP32    = 64'hFFFF_FFFF;
  localparam logic signed [63:0] S32_MAX  = 64'sd2147483647;
  localparam logic signed [63:0] S32_MIN  = -64'sd2147483648;
  localparam logic signed [63:0] US_IN_S  = 64'sd1000000;

  // Predicted configuration and filter state.
  logic [31:0]        proc_noise;
  logic [31:0]        meas_noise;
  logic signed [31:0] last_dist;
  logic [47:0]        last_stamp;
  logic signed [31:0] vel_est;
  logic [31:0]        cov_est;

  // Results still owed by the block, oldest first.
  out_item_t velocity_due[$];
  out_item_t seen;
  out_item_t want;
  int        errs = 0;

  function automatic logic signed [63:0] clamp_s32(input logic signed [63:0] v);
    logic signed [63:0] r;
    r = v;
    if (v > S32_MAX) r = S32_MAX;
    if (v < S32_MIN) r = S32_MIN;
    return r;
  endfunction

  // Compare one field of a result and report any difference.
  task automatic check_field(input string name, input longint exp_v, input longint got_v);
    if (exp_v != got_v) begin
      errs++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, got_v);
    end
  endtask

  // Differentiate the distance, add the own speed and run the Kalman update.
  task automatic track_velocity(input in_item_t pkt);
    logic signed [63:0] dist_now, dist_chg, raw, spd, rel, innov, gain_s, prod, upd;
    logic signed [63:0] span;
    logic [47:0]        dt;
    logic [63:0]        pm, den, gain, pnext;
    out_item_t          res;
    dist_now   = pkt.target_distance;
    dist_chg   = dist_now - last_dist;
    dt         = pkt.sample_time - last_stamp;
    last_dist  = pkt.target_distance;
    last_stamp = pkt.sample_time;

    // A zero time step saturates by the sign of the distance change.
    if (dt == '0) begin
      raw = (dist_chg > 0) ? S32_MAX : ((dist_chg < 0) ? S32_MIN : 64'sd0);
    end else begin
      span = {16'd0, dt};
      raw  = clamp_s32((dist_chg * US_IN_S) / span);
    end

    // The magnitude of the most negative speed is capped at the largest positive one.
    spd = pkt.own_speed;
    if (spd < 0) spd = -spd;
    if (spd > S32_MAX) spd = S32_MAX;
    rel = clamp_s32(raw + spd);

    // The filter is only updated when time has moved on.
    if (dt != '0) begin
      pm = {32'd0, cov_est} + {32'd0, proc_noise};
      if (pm > CAP32) pm = CAP32;
      den  = pm + {32'd0, meas_noise};
      gain = (den != 0) ? (pm << COV_FRAC_BITS) / den : 64'd0;
      if (gain > GAIN_ONE) gain = GAIN_ONE;
      gain_s  = gain;
      innov   = rel - vel_est;
      prod    = innov * gain_s;
      upd     = clamp_s32(vel_est + (prod >>> COV_FRAC_BITS));
      vel_est = upd[31:0];
      pnext   = ((GAIN_ONE - gain) * pm) >> COV_FRAC_BITS;
      if (pnext > CAP32) pnext = CAP32;
      cov_est = pnext[31:0];
    end

    res.relative_velocity = rel[31:0];
    res.filtered_velocity = vel_est;
    res.time_error        = (dt == '0);
    velocity_due.push_back(res);
  endtask

  // Retire results before predicting, so that a transaction in the same cycle
  // on both channels is handled in order.
  always @(posedge clk) begin
    if (rst) begin
      proc_noise = 32'((GAIN_ONE + 64'd500) / 64'd1000);
      meas_noise = 32'((GAIN_ONE + 64'd5) / 64'd10);
      last_dist  = '0;
      last_stamp = '0;
      vel_est    = '0;
      cov_est    = 32'(GAIN_ONE);
      velocity_due.delete();
      mismatches  <= errs;
      outstanding <= 0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          CFG_PROCESS_NOISE:     proc_noise = cfg_data;
          CFG_MEASUREMENT_NOISE: meas_noise = cfg_data;
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        seen = out_data;
        if (velocity_due.size() == 0) begin
          errs++;
          $display("%0t: unexpected result, expected none, actual rel %0d filt %0d err %0b",
                   $time, seen.relative_velocity, seen.filtered_velocity,
                   seen.time_error);
        end else begin
          want = velocity_due.pop_front();
          check_field("relative_velocity", want.relative_velocity, seen.relative_velocity);
          check_field("filtered_velocity", want.filtered_velocity, seen.filtered_velocity);
          check_field("time_error", want.time_error, seen.time_error);
        end
      end
      if (in_valid && in_ready && in_data.target_present) begin
        track_velocity(in_data);
      end
      mismatches  <= errs;
      outstanding <= velocity_due.size();
    end
  end

endmodule

[dv/tb.sv]
`timescale 1ns / 100ps
// Testbench top for the velocity Kalman tracker core: clock, reset, stimulus,
// random back-pressure and the verdict. Depends on vkt_pkg and velocity_track_checker.
module tb;
  import vkt_pkg::*;

  localparam int PHASES           = 8;
  localparam int RANDOM_PER_PHASE = 141;
  localparam int SETTLE_CYCLES    = 100;
  localparam int STALL_LIMIT      = 2000;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  in_item_t    in_data;
  logic        out_valid;
  logic        out_ready;
  out_item_t   out_data;
  logic        cfg_write;
  logic [0:0]  cfg_index;
  logic [31:0] cfg_data;
  int          mismatches;
  int          outstanding;

  // Stimulus bookkeeping: time and distance of the last target sent.
  bit                 quiet = 1'b0;
  logic [47:0]        track_time = '0;
  logic signed [31:0] track_dist = '0;
  int                 idle_cycles = 0;

  velocity_kalman_tracker_core i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  velocity_track_checker i_checker (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic int draw_gap();
    return quiet ? 0 : int'($urandom_range(0, 7));
  endfunction

  function automatic in_item_t mk(input bit present, input logic [31:0] range_m,
                                  input logic [47:0] stamp, input logic [31:0] spd);
    in_item_t pkt;
    pkt.target_present  = present;
    pkt.target_distance = range_m;
    pkt.sample_time     = stamp;
    pkt.own_speed       = spd;
    return pkt;
  endfunction

  // Build the next random transaction; most are plausible target tracks.
  function automatic in_item_t next_sample();
    in_item_t pkt;
    int       kind;
    longint   dt_us, vel, shift;
    kind = $urandom_range(0, 99);
    pkt  = mk(1'b1, $urandom, {16'($urandom), $urandom}, $urandom);
    if (kind < 12) begin
      pkt.target_present = 1'b0;
      return pkt;
    end
    if (kind >= 20 && kind < 25) begin
      // Repeated timestamp.
      pkt.sample_time = track_time;
      if (kind < 23) pkt.target_distance = track_dist + 32'($urandom_range(0, 200)) - 32'd100;
    end else if (kind >= 25) begin
      // A plausible step on the track; kind 25 first moves the time just below its wrap.
      if (kind == 25) track_time = 48'hFFFF_FFFF_FFFF - 48'($urandom_range(0, 300000));
      case ($urandom_range(0, 9))
        0:       dt_us = $urandom_range(1, 1000);
        8:       dt_us = $urandom_range(1, 5000000);
        9:       dt_us = {16'($urandom), $urandom};
        default: dt_us = $urandom_range(20000, 200000);
      endcase
      vel   = longint'($urandom_range(0, 32'd13107200)) - 64'sd6553600;
      shift = vel * dt_us / 1000000 + longint'($urandom_range(0, 2000)) - 64'sd1000;
      pkt.sample_time     = track_time + 48'(dt_us);
      pkt.target_distance = track_dist + 32'(shift);
      pkt.own_speed       = 32'($urandom_range(0, 32'd5242880)) - 32'd2621440;
    end
    track_time = pkt.sample_time;
    track_dist = pkt.target_distance;
    return pkt;
  endfunction

  // Present one transaction and hold it until it is taken.
  task automatic push_sample(input in_item_t pkt);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= pkt;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Let every owed result arrive, then give the block time to fall idle.
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_noise(input logic [31:0] pnoise, input logic [31:0] mnoise);
    wait_idle();
    cfg_write <= 1'b1;
    cfg_index <= CFG_PROCESS_NOISE;
    cfg_data  <= pnoise;
    @(posedge clk);
    cfg_index <= CFG_MEASUREMENT_NOISE;
    cfg_data  <= mnoise;
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  // Receiver: a random stall before each result, none while quiet.
  initial begin : drain_results
    int stall;
    out_ready <= 1'b0;
    @(posedge clk);
    forever begin
      stall = draw_gap();
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  // Watchdog on cycles without any transaction.
  always @(posedge clk) begin
    if (rst || cfg_write || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin : stimulus
    rst       <= 1'b1;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_write <= 1'b0;
    cfg_index <= CFG_PROCESS_NOISE;
    cfg_data  <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed opening: field extremes, zero time steps, time wrap, absent targets.
    push_sample(mk(1'b0, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF));
    push_sample(mk(1'b1, 32'd0, 48'd0, 32'd0));
    push_sample(mk(1'b1, 32'h7FFF_FFFF, 48'd0, 32'h8000_0000));
    push_sample(mk(1'b1, 32'h8000_0000, 48'd0, 32'd0));
    push_sample(mk(1'b1, 32'h7FFF_FFFF, 48'd1, 32'h7FFF_FFFF));
    push_sample(mk(1'b1, 32'h8000_0000, 48'd2, 32'hFFFF_FFFF));
    push_sample(mk(1'b1, 32'd0, 48'hFFFF_FFFF_FFFF, 32'd0));
    push_sample(mk(1'b1, 32'd65536, 48'd99999, 32'd655360));
    push_sample(mk(1'b0, 32'd0, 48'd0, 32'd0));
    push_sample(mk(1'b1, 32'd131072, 48'd199999, -32'sd655360));
    push_sample(mk(1'b1, 32'd196608, 48'd299999, 32'd0));
    push_sample(mk(1'b1, 32'd196608, 48'd299999, 32'd0));
    push_sample(mk(1'b1, 32'd262144, 48'h8000_0000_0000, 32'h7FFF_FFFF));
    push_sample(mk(1'b1, -32'sd100, 48'h8000_0000_0001, 32'd0));
    track_time = 48'h8000_0000_0001;
    track_dist = -32'sd100;
    for (int n = 0; n < 5; n++) push_sample(next_sample());

    // Random phases, each under its own noise setting.
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: ;
        1: set_noise(32'd0, 32'd0);
        2: set_noise(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        3: set_noise(32'd0, 32'hFFFF_FFFF);
        4: set_noise(32'hFFFF_FFFF, 32'd0);
        default: set_noise($urandom_range(0, 32'h0400_0000), $urandom);
      endcase
      for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
        if (n % 32 == 0) quiet = ($urandom_range(0, 3) == 0);
        push_sample(next_sample());
      end
    end

    wait_idle();
    if (mismatches == 0 && outstanding == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
